>>> src/ific_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the instruction fetch stage with l1 icache
// no dependencies; used by ific_store and instruction_fetch_with_l1_icache
package ific_pkg;

    localparam int WORD_W        = 32;
    localparam int L2_MAX_WORDS  = 8;
    localparam int CFG_ADDR_W    = 3;

    localparam int SETS_DEF          = 64;
    localparam int WAYS_DEF          = 2;
    localparam int L1_LINE_WORDS_DEF = 4;
    localparam int L2_LINE_WORDS_DEF = 8;

    localparam logic [WORD_W-1:0] NOP_WORD = 32'h0000_0013;
    localparam logic [WORD_W-1:0] PC_STEP  = 32'd4;

    // register index, taken from paddr[2]
    localparam logic REG_REPLACE_MODE = 1'b0;

    // commands from the fetch control to the cache store
    typedef struct packed {
        logic lookup;
        logic fill;
        logic lru;
    } ific_ctrl_t;

    // lookup result for the current pc
    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] word;
    } ific_look_t;

endpackage

>>> src/ific_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module ific_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // write-first on a collision
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ific_store.sv
`timescale 1ns / 1ps
// l1 icache storage: per-way tag and data rams, valid bits, age ranks,
// hit compare and victim choice; depends on ific_pkg and ific_ram
module ific_store
    import ific_pkg::*;
#(
    parameter int SETS          = SETS_DEF,
    parameter int WAYS          = WAYS_DEF,
    parameter int L1_LINE_WORDS = L1_LINE_WORDS_DEF,
    parameter int L2_LINE_WORDS = L2_LINE_WORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ific_ctrl_t                       ctrl,
    input  logic [WORD_W-1:0]                pc,
    input  logic [WORD_W-1:0]                rd_pc,
    input  logic [L2_MAX_WORDS*WORD_W-1:0]   l2_line,
    output ific_look_t                       look
);

    localparam int OFF_W   = $clog2(L1_LINE_WORDS);
    localparam int SET_W   = $clog2(SETS);
    localparam int OFF_IW  = (OFF_W > 0) ? OFF_W : 1;
    localparam int SET_IW  = (SET_W > 0) ? SET_W : 1;
    localparam int TAG_W   = WORD_W - 2 - OFF_W - SET_W;
    localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_W  = L1_LINE_WORDS * WORD_W;
    localparam int IDX_W   = $clog2(L2_MAX_WORDS);

    typedef logic [WAYS-1:0][RANK_W-1:0] rank_row_t;

    logic [WAYS-1:0] valid_reg [SETS];
    rank_row_t       rank_reg  [SETS];

    logic [WORD_W-3:0] cur_word;
    logic [WORD_W-3:0] rd_word;
    logic [WORD_W-3:0] set_tmp;
    logic [WORD_W-3:0] rd_set_tmp;
    logic [WORD_W-3:0] off_tmp;
    logic [SET_IW-1:0] cur_set;
    logic [SET_IW-1:0] rd_set;
    logic [OFF_IW-1:0] cur_off;
    logic [TAG_W-1:0]  cur_tag;

    logic [TAG_W-1:0]  tag_rdata  [WAYS];
    logic [LINE_W-1:0] data_rdata [WAYS];
    logic [LINE_W-1:0] fill_line;
    logic [WAYS-1:0]   way_we;

    logic [WAYS-1:0]   vrow;
    rank_row_t         rrow;
    rank_row_t         rrow_next;
    logic              hit;
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] victim;
    logic [RANK_W-1:0] upd_way;
    logic [RANK_W-1:0] old_rank;
    logic              touch;
    logic              found;
    logic [IDX_W-1:0]  first;
    logic [IDX_W:0]    k;

    // address split; while a fill is pending the pc still holds the missed address,
    // so lookups, fills and rank updates all work on the set of the current pc
    assign cur_word   = pc[WORD_W-1:2];
    assign rd_word    = rd_pc[WORD_W-1:2];
    assign set_tmp    = (cur_word >> OFF_W) & (WORD_W-2)'(SETS - 1);
    assign rd_set_tmp = (rd_word >> OFF_W) & (WORD_W-2)'(SETS - 1);
    assign off_tmp    = cur_word & (WORD_W-2)'(L1_LINE_WORDS - 1);
    assign cur_set    = set_tmp[SET_IW-1:0];
    assign rd_set     = rd_set_tmp[SET_IW-1:0];
    assign cur_off    = off_tmp[OFF_IW-1:0];
    assign cur_tag    = TAG_W'(cur_word >> (OFF_W + SET_W));

    assign vrow = valid_reg[cur_set];
    assign rrow = rank_reg[cur_set];

    // l1-sized slice of the l2 line, words past the l2 line read as zero
    always_comb
    begin
        first = IDX_W'(cur_word[IDX_W-1:0] & IDX_W'(L2_LINE_WORDS - 1)
                       & ~IDX_W'(L1_LINE_WORDS - 1));
        fill_line = '0;
        k = '0;
        for (int i = 0; i < L1_LINE_WORDS; i++)
        begin
            k = {1'b0, first} + (IDX_W+1)'(i);
            if (k < (IDX_W+1)'(L2_LINE_WORDS))
            begin
                fill_line[i*WORD_W +: WORD_W] = l2_line[k[IDX_W-1:0]*WORD_W +: WORD_W];
            end
        end
    end

    // hit: lowest matching valid way
    always_comb
    begin
        hit = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && vrow[w] && (tag_rdata[w] == cur_tag))
            begin
                hit = 1'b1;
                hit_way = RANK_W'(w);
            end
        end
    end

    assign look.hit  = hit;
    assign look.word = data_rdata[hit_way][cur_off*WORD_W +: WORD_W];

    // victim: lowest invalid way, else the way of rank zero (ranks form a permutation)
    always_comb
    begin
        victim = '0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!found && !vrow[w])
            begin
                victim = RANK_W'(w);
                found = 1'b1;
            end
        end
        if (!found)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (rrow[w] == '0)
                begin
                    victim = RANK_W'(w);
                end
            end
        end
    end

    assign touch   = ctrl.fill || (ctrl.lookup && ctrl.lru && hit);
    assign upd_way = ctrl.fill ? victim : hit_way;

    always_comb
    begin
        old_rank = rrow[upd_way];
        for (int w = 0; w < WAYS; w++)
        begin
            if (RANK_W'(w) == upd_way)
            begin
                rrow_next[w] = RANK_W'(WAYS - 1);
            end
            else if (rrow[w] > old_rank)
            begin
                rrow_next[w] = rrow[w] - 1'b1;
            end
            else
            begin
                rrow_next[w] = rrow[w];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
                for (int w = 0; w < WAYS; w++)
                begin
                    rank_reg[s][w] <= RANK_W'(w);
                end
            end
        end
        else
        begin
            if (ctrl.fill)
            begin
                valid_reg[cur_set][victim] <= 1'b1;
            end
            if (touch)
            begin
                rank_reg[cur_set] <= rrow_next;
            end
        end
    end

    generate
        for (genvar w = 0; w < WAYS; w++)
        begin : g_way
            assign way_we[w] = ctrl.fill && (victim == RANK_W'(w));

            ific_ram #(
                .WIDTH (TAG_W),
                .DEPTH (SETS)
            ) u_tag_ram (
                .clk   (clk),
                .we    (way_we[w]),
                .waddr (cur_set),
                .wdata (cur_tag),
                .raddr (rd_set),
                .rdata (tag_rdata[w])
            );

            ific_ram #(
                .WIDTH (LINE_W),
                .DEPTH (SETS)
            ) u_data_ram (
                .clk   (clk),
                .we    (way_we[w]),
                .waddr (cur_set),
                .wdata (fill_line),
                .raddr (rd_set),
                .rdata (data_rdata[w])
            );
        end
    endgenerate

endmodule

>>> src/instruction_fetch_with_l1_icache.sv
`timescale 1ns / 1ps
// fetch stage with set-associative l1 instruction cache: control, apb register, result register
// depends on ific_pkg, ific_store (and through it ific_ram)
//
//  channel  handshake          payload
//  in       in_valid/in_ready  bubble hazard redirect_pc l2_ready l2_words_01..67
//  out      out_valid/out_ready instruction instruction_address l2_request
//                              l2_line_address fetch_hit fetch_miss
//  cfg      apb psel/penable   paddr[2:0] pwdata prdata, pready tied high
//
// one word per cycle while in_ready is high; the result shows in the cycle after acceptance
// tag and data rams are read with the next pc, so their registered output is ready
// for the following word; a fill writes through to that read
// reset clears pc, state, valid bits, sets age ranks to way order at once; no clearing pass
// in_ready drops only while a result waits and out_ready is low
// sets, l1 and l2 line words are powers of two
module instruction_fetch_with_l1_icache
    import ific_pkg::*;
#(
    parameter int SETS          = SETS_DEF,
    parameter int WAYS          = WAYS_DEF,
    parameter int L1_LINE_WORDS = L1_LINE_WORDS_DEF,
    parameter int L2_LINE_WORDS = L2_LINE_WORDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  bubble,
    input  logic                  hazard,
    input  logic [WORD_W-1:0]     redirect_pc,
    input  logic                  l2_ready,
    input  logic [63:0]           l2_words_01,
    input  logic [63:0]           l2_words_23,
    input  logic [63:0]           l2_words_45,
    input  logic [63:0]           l2_words_67,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORD_W-1:0]     instruction,
    output logic [WORD_W-1:0]     instruction_address,
    output logic                  l2_request,
    output logic [WORD_W-1:0]     l2_line_address,
    output logic                  fetch_hit,
    output logic                  fetch_miss,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic [WORD_W-1:0] LINE_MASK = ~(WORD_W'(L2_LINE_WORDS * 4 - 1));

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] pc_reg;
    logic [WORD_W-1:0] pc_next;
    logic              waiting_reg;
    logic              waiting_next;
    logic [WORD_W-1:0] instr_reg;
    logic [WORD_W-1:0] instr_next;
    logic [WORD_W-1:0] addr_reg;
    logic [WORD_W-1:0] addr_next;
    logic [WORD_W-1:0] req_reg;
    logic [WORD_W-1:0] req_next;
    logic              hit_reg;
    logic              hit_next;
    logic              miss_reg;
    logic              miss_next;
    logic              mode_reg;
    logic              mode_next;

    logic              fire;
    logic              cfg_wr;
    ific_ctrl_t        ctrl;
    ific_look_t        look;
    logic [L2_MAX_WORDS*WORD_W-1:0] l2_line;

    assign l2_line  = {l2_words_67, l2_words_45, l2_words_23, l2_words_01};
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_REPLACE_MODE) ? {31'b0, mode_reg} : 32'b0;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_wr && (paddr[2] == REG_REPLACE_MODE))
        begin
            mode_next = pwdata[0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pc_next        = pc_reg;
        waiting_next   = waiting_reg;
        instr_next     = instr_reg;
        addr_next      = addr_reg;
        req_next       = req_reg;
        hit_next       = hit_reg;
        miss_next      = miss_reg;
        ctrl.lookup    = 1'b0;
        ctrl.fill      = 1'b0;
        ctrl.lru       = mode_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
            hit_next       = 1'b0;
            miss_next      = 1'b0;
            if (waiting_reg)
            begin
                // controls are ignored until the line arrives
                ctrl.fill    = l2_ready;
                waiting_next = !l2_ready;
                instr_next   = NOP_WORD;
                addr_next    = pc_reg;
            end
            else if (bubble)
            begin
                instr_next = NOP_WORD;
                addr_next  = pc_reg;
                pc_next    = redirect_pc;
            end
            else if (hazard)
            begin
                // hold pc and the previous word
            end
            else
            begin
                ctrl.lookup = 1'b1;
                addr_next   = pc_reg;
                if (look.hit)
                begin
                    hit_next   = 1'b1;
                    instr_next = look.word;
                    pc_next    = pc_reg + PC_STEP;
                end
                else
                begin
                    miss_next    = 1'b1;
                    instr_next   = NOP_WORD;
                    req_next     = pc_reg & LINE_MASK;
                    waiting_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            waiting_reg   <= 1'b0;
            instr_reg     <= NOP_WORD;
            addr_reg      <= '0;
            req_reg       <= '0;
            hit_reg       <= 1'b0;
            miss_reg      <= 1'b0;
            mode_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
            waiting_reg   <= waiting_next;
            instr_reg     <= instr_next;
            addr_reg      <= addr_next;
            req_reg       <= req_next;
            hit_reg       <= hit_next;
            miss_reg      <= miss_next;
            mode_reg      <= mode_next;
        end
    end

    ific_store #(
        .SETS          (SETS),
        .WAYS          (WAYS),
        .L1_LINE_WORDS (L1_LINE_WORDS),
        .L2_LINE_WORDS (L2_LINE_WORDS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .pc      (pc_reg),
        .rd_pc   (pc_next),
        .l2_line (l2_line),
        .look    (look)
    );

    // fetch state doubles as the result register
    assign out_valid           = out_valid_reg;
    assign instruction         = instr_reg;
    assign instruction_address = addr_reg;
    assign l2_request          = waiting_reg;
    assign l2_line_address     = req_reg;
    assign fetch_hit           = hit_reg;
    assign fetch_miss          = miss_reg;

endmodule
